>>> rtl/core/i2bd_pkg.sv
// Shared types, constants and the digit-to-character function of the radix converter.
`default_nettype none
package i2bd_pkg;

	localparam int DIGIT_W = 4;
	localparam int RADIX_W = 5;

	localparam logic [RADIX_W-1:0] RADIX_MIN     = 5'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX     = 5'd16;
	localparam logic [RADIX_W-1:0] DECIMAL_RADIX = 5'd10;

	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_MINUS = 8'h2d;
	// 'a' minus ten, so that a digit of ten or more maps straight to its letter.
	localparam logic [7:0] CHAR_ALPHA_BASE = 8'h57;
	localparam logic [DIGIT_W-1:0] DIGIT_TEN = 4'd10;

	typedef struct packed {
		logic clear;
		logic shift;
	} cell_ctrl_t;

	function automatic logic [7:0] digit_char(input logic [DIGIT_W-1:0] d);
		logic [7:0] base;
		base = (d < DIGIT_TEN) ? CHAR_ZERO : CHAR_ALPHA_BASE;
		return base + {4'd0, d};
	endfunction

endpackage
`default_nettype wire

>>> rtl/core/i2bd_cell.sv
// One digit cell: doubles its digit, adds the carry from below and passes its carry upward.
`default_nettype none
module i2bd_cell (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire i2bd_pkg::cell_ctrl_t            ctrl,
	input  wire logic [i2bd_pkg::RADIX_W-1:0]    radix,
	input  wire                                  cin,
	output logic                                 cout,
	output logic [i2bd_pkg::DIGIT_W-1:0]         digit
);
	import i2bd_pkg::*;

	logic [DIGIT_W-1:0] digit_q;
	logic               gen;
	logic               prop;
	logic [RADIX_W-1:0] sum;
	logic [RADIX_W-1:0] reduced;

	// The digit is below the radix, so twice it plus one never reaches twice the radix
	// and a single conditional subtract brings it back into range.
	always_comb begin
		gen     = ({digit_q, 1'b0} >= radix);
		prop    = ({digit_q, 1'b1} == radix);
		cout    = gen | (prop & cin);
		sum     = {digit_q, cin};
		reduced = cout ? (sum - radix) : sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q <= '0;
		end else if (ctrl.clear) begin
			digit_q <= '0;
		end else if (ctrl.shift) begin
			digit_q <= reduced[DIGIT_W-1:0];
		end
	end

	assign digit = digit_q;

endmodule
`default_nettype wire

>>> rtl/core/integer_to_base_digits.sv
// Top level of the integer to radix digit converter: sequencer, row of digit cells, output register.
//
// Slave channel: s_tdata carries the word to convert and its radix, s_tuser the unsigned flag.
// Master channel: one item per character, most significant first; tlast marks the last one.
// Radix values below 2 or above 16 are treated as 2 and 16. A negative signed word gives a
// leading '-' in radix 10 and only the digits of its magnitude in any other radix.
// Operation: the magnitude is shifted in one bit per cycle, most significant bit first, into a
// row of WORD_BITS digit cells; each cell doubles its digit and passes a carry to the next one.
// Conversion shifts in all WORD_BITS bits, then the characters are emitted one by one (sign plus digits).
// A new item is taken once the last character has been loaded into the output register,
// even if that character is still waiting.
// A stalled receiver holds the output register and the sequencer waits; nothing is dropped.
// Reset returns the block to idle with an empty output register.
`default_nettype none
module integer_to_base_digits #(
	parameter int WORD_BITS = 32
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               s_tvalid,
	output logic              s_tready,
	input  wire  [39:0]       s_tdata,   // [31:0] value, [36:32] radix, [39:37] zero
	input  wire  [0:0]        s_tuser,   // [0] unsigned_mode
	output logic              m_tvalid,
	input  wire               m_tready,
	output logic [7:0]        m_tdata,   // [7:0] char_code
	output logic              m_tlast
);
	import i2bd_pkg::*;

	localparam int CNT_W = $clog2(WORD_BITS + 1);
	localparam int IDX_W = $clog2(WORD_BITS);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CONV = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]             state_q;
	logic [WORD_BITS-1:0]   mag_q;
	logic [RADIX_W-1:0]     radix_q;
	logic                   sign_q;
	logic [CNT_W-1:0]       bits_q;
	logic [CNT_W-1:0]       count_q;
	logic [IDX_W-1:0]       idx_q;
	logic                   m_tvalid_q;
	logic [7:0]             m_tdata_q;
	logic                   m_tlast_q;

	logic [WORD_BITS+31:0]  value_ext;
	logic [WORD_BITS-1:0]   value_w;
	logic                   neg;
	logic [WORD_BITS-1:0]   magnitude;
	logic [RADIX_W-1:0]     radix_in;
	logic [RADIX_W-1:0]     radix_sat;
	logic                   accept;
	logic                   out_free;
	logic                   emit;
	logic                   emit_last;
	logic [7:0]             emit_char;
	logic [IDX_W-1:0]       top_idx;
	logic                   grow;
	logic [CNT_W-1:0]       count_next;
	logic [IDX_W-1:0]       first_idx;

	cell_ctrl_t             cell_ctrl;
	logic [WORD_BITS-1:0]   carry;
	logic [WORD_BITS-1:0]   cin;
	logic [DIGIT_W-1:0]     digits [WORD_BITS];

	always_comb begin
		value_ext = {{WORD_BITS{1'b0}}, s_tdata[31:0]};
		value_w   = value_ext[WORD_BITS-1:0];
		neg       = !s_tuser[0] && value_w[WORD_BITS-1];
		magnitude = neg ? ((~value_w) + WORD_BITS'(1)) : value_w;
		radix_in  = s_tdata[36:32];
		priority if (radix_in < RADIX_MIN) begin
			radix_sat = RADIX_MIN;
		end else if (radix_in > RADIX_MAX) begin
			radix_sat = RADIX_MAX;
		end else begin
			radix_sat = radix_in;
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	assign cell_ctrl.clear = accept;
	assign cell_ctrl.shift = (state_q == ST_CONV);

	// The value at most doubles plus one per step, so the significant digit count grows by at most one;
	// it grows exactly when the current top digit hands a carry upward.
	always_comb begin
		top_idx    = IDX_W'(count_q - CNT_W'(1));
		grow       = carry[top_idx];
		count_next = count_q + CNT_W'(grow);
		first_idx  = IDX_W'(count_next - CNT_W'(1));
	end

	genvar gi;
	generate
		for (gi = 0; gi < WORD_BITS; gi++) begin : g_cell
			if (gi == 0) begin : g_first
				assign cin[gi] = mag_q[WORD_BITS-1];
			end else begin : g_rest
				assign cin[gi] = carry[gi-1];
			end
			i2bd_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.ctrl   (cell_ctrl),
				.radix  (radix_q),
				.cin    (cin[gi]),
				.cout   (carry[gi]),
				.digit  (digits[gi])
			);
		end
	endgenerate

	always_comb begin
		emit      = (state_q == ST_EMIT) && out_free;
		emit_last = !sign_q && (idx_q == '0);
		emit_char = sign_q ? CHAR_MINUS : digit_char(digits[idx_q]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mag_q   <= '0;
			radix_q <= RADIX_MIN;
			sign_q  <= 1'b0;
			bits_q  <= '0;
			count_q <= CNT_W'(1);
			idx_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						mag_q   <= magnitude;
						radix_q <= radix_sat;
						sign_q  <= neg && (radix_sat == DECIMAL_RADIX);
						bits_q  <= CNT_W'(WORD_BITS);
						count_q <= CNT_W'(1);
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					mag_q   <= {mag_q[WORD_BITS-2:0], 1'b0};
					bits_q  <= bits_q - CNT_W'(1);
					count_q <= count_next;
					if (bits_q == CNT_W'(1)) begin
						idx_q   <= first_idx;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit) begin
						if (sign_q) begin
							sign_q <= 1'b0;
						end else if (emit_last) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q - IDX_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (emit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			m_tdata_q <= emit_char;
			m_tlast_q <= emit_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

`ifndef ASSERT_OFF
	a_no_top_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CONV) |-> !carry[WORD_BITS-1])
		else $error("carry left the top digit cell");

	a_digit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> ({1'b0, digits[idx_q]} < radix_q))
		else $error("digit cell holds a value not below the radix");

	a_no_leading_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && $past(state_q) == ST_CONV && count_q > CNT_W'(1))
		|-> (digits[IDX_W'(count_q - CNT_W'(1))] != '0))
		else $error("most significant digit is zero");

	a_last_returns_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && emit_last) |=> (state_q == ST_IDLE && m_tvalid && m_tlast))
		else $error("last character did not end the conversion");
`endif

endmodule
`default_nettype wire
